// File: rtl/core/ac3hp_pkg.sv
package ac3hp_pkg;

  // Width of the saturating byte counter.
  localparam int COUNT_BITS = 13;
  localparam int HDR_BYTES  = 7;

  localparam logic [7:0] SYNC_HI = 8'h0B;
  localparam logic [7:0] SYNC_LO = 8'h77;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MORE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Frame size in 16-bit words, one table per AC-3 sample rate code.
  localparam logic [10:0] WORDS_48K [38] = '{
    11'd64,   11'd64,   11'd80,   11'd80,   11'd96,   11'd96,   11'd112,  11'd112,
    11'd128,  11'd128,  11'd160,  11'd160,  11'd192,  11'd192,  11'd224,  11'd224,
    11'd256,  11'd256,  11'd320,  11'd320,  11'd384,  11'd384,  11'd448,  11'd448,
    11'd512,  11'd512,  11'd640,  11'd640,  11'd768,  11'd768,  11'd896,  11'd896,
    11'd1024, 11'd1024, 11'd1152, 11'd1152, 11'd1280, 11'd1280};
  localparam logic [10:0] WORDS_44K [38] = '{
    11'd69,   11'd70,   11'd87,   11'd88,   11'd104,  11'd105,  11'd121,  11'd122,
    11'd139,  11'd140,  11'd174,  11'd175,  11'd208,  11'd209,  11'd243,  11'd244,
    11'd278,  11'd279,  11'd348,  11'd349,  11'd417,  11'd418,  11'd487,  11'd488,
    11'd557,  11'd558,  11'd696,  11'd697,  11'd835,  11'd836,  11'd975,  11'd976,
    11'd1114, 11'd1115, 11'd1253, 11'd1254, 11'd1393, 11'd1394};
  localparam logic [10:0] WORDS_32K [38] = '{
    11'd96,   11'd96,   11'd120,  11'd120,  11'd144,  11'd144,  11'd168,  11'd168,
    11'd192,  11'd192,  11'd240,  11'd240,  11'd288,  11'd288,  11'd336,  11'd336,
    11'd384,  11'd384,  11'd480,  11'd480,  11'd576,  11'd576,  11'd672,  11'd672,
    11'd768,  11'd768,  11'd960,  11'd960,  11'd1152, 11'd1152, 11'd1344, 11'd1344,
    11'd1536, 11'd1536, 11'd1728, 11'd1728, 11'd1920, 11'd1920};

  // Full-bandwidth channel count for each acmod.
  localparam logic [2:0] CHAN_TAB [8] = '{3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5};

  // Header snapshot handed from the capture stage to the decoder.
  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] hdr;
    logic [COUNT_BITS-1:0]     count;
    logic                      enhanced;
  } snap_t;

  typedef struct packed {
    status_t         status;
    logic [12:0]     frame_bytes;
    logic [15:0]     sample_rate;
    logic [10:0]     samples_per_frame;
    logic [5:0]      frame_size_code;
    logic [4:0]      stream_id;
    logic [2:0]      service_mode;
    logic [2:0]      coding_mode;
    logic [2:0]      channel_count;
    logic            lfe_on;
  } res_t;

  function automatic logic [15:0] base_rate(input logic [1:0] fs);
    logic [15:0] r;
    case (fs)
      2'd0:    r = 16'd48000;
      2'd1:    r = 16'd44100;
      2'd2:    r = 16'd32000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] half_rate(input logic [1:0] code);
    logic [15:0] r;
    case (code)
      2'd0:    r = 16'd24000;
      2'd1:    r = 16'd22050;
      2'd2:    r = 16'd16000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] ac3_words(input logic [5:0] code, input logic [1:0] fs);
    logic [10:0] w;
    case (fs)
      2'd0:    w = WORDS_48K[code];
      2'd1:    w = WORDS_44K[code];
      2'd2:    w = WORDS_32K[code];
      default: w = 11'd0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/ac3hp_if.sv
interface ac3hp_in_if;
  import ac3hp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ac3hp_out_if;
  import ac3hp_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [12:0] frame_bytes;
  logic [15:0] sample_rate;
  logic [10:0] samples_per_frame;
  logic [5:0]  frame_size_code;
  logic [4:0]  stream_id;
  logic [2:0]  service_mode;
  logic [2:0]  coding_mode;
  logic [2:0]  channel_count;
  logic        lfe_on;

  modport source (output valid, status, frame_bytes, sample_rate, samples_per_frame,
                  frame_size_code, stream_id, service_mode, coding_mode, channel_count,
                  lfe_on, input ready);
  modport sink   (input valid, status, frame_bytes, sample_rate, samples_per_frame,
                  frame_size_code, stream_id, service_mode, coding_mode, channel_count,
                  lfe_on, output ready);
endinterface

// File: rtl/core/ac3hp_capture.sv
module ac3hp_capture import ac3hp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  ac3hp_in_if.sink        in_ch,
  input  logic            cfg_we,
  input  logic            cfg_data,
  input  logic            snap_take,
  output logic            snap_valid,
  output snap_t           snap
);

  logic [COUNT_BITS-1:0]          cnt_r, cnt_nxt, cnt_inc;
  logic [HDR_BYTES-1:0][7:0]      store_r;
  logic [HDR_BYTES-1:0][7:0]      hdr_merged;
  logic                           mode_r;
  logic                           snap_vld_r, snap_vld_nxt;
  snap_t                          snap_r;
  logic                           accept;

  assign in_ch.ready = !snap_vld_r || snap_take;
  assign accept      = in_ch.valid && in_ch.ready;

  // The count saturates at all ones, far above any legal frame length.
  assign cnt_inc = (cnt_r == {COUNT_BITS{1'b1}}) ? cnt_r : cnt_r + COUNT_BITS'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_ch.last_byte ? '0 : cnt_inc;
    end
  end

  // The byte in flight joins the stored ones so the snapshot is complete.
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_merged[i] = (cnt_r == COUNT_BITS'(i)) ? in_ch.data_byte : store_r[i];
    end
  end

  always_comb begin
    snap_vld_nxt = snap_vld_r;
    if (snap_take) begin
      snap_vld_nxt = 1'b0;
    end
    if (accept && in_ch.last_byte) begin
      snap_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      mode_r     <= 1'b0;
      snap_vld_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      snap_vld_r <= snap_vld_nxt;
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cnt_r < COUNT_BITS'(HDR_BYTES))) begin
      store_r[cnt_r[2:0]] <= in_ch.data_byte;
    end
    if (accept && in_ch.last_byte) begin
      snap_r.hdr      <= hdr_merged;
      snap_r.count    <= cnt_inc;
      snap_r.enhanced <= mode_r;
    end
  end

  assign snap_valid = snap_vld_r;
  assign snap       = snap_r;

endmodule

// File: rtl/core/ac3hp_decode.sv
module ac3hp_decode import ac3hp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            snap_valid,
  input  snap_t           snap,
  output logic            snap_take,
  ac3hp_out_if.source     out_ch
);

  logic                  out_vld_r, out_vld_nxt;
  res_t                  res_r, res_nxt;
  logic                  sync_ok;
  logic [7:0]            b2, b3, b4, b5, b6;
  logic [1:0]            fs, nb;
  logic [5:0]            code;
  logic [2:0]            acm_std, acm_enh;
  logic [12:0]           len_std, len_enh;
  logic [2:0]            lfe_idx;

  assign snap_take = snap_valid && (!out_vld_r || out_ch.ready);

  assign b2      = snap.hdr[2];
  assign b3      = snap.hdr[3];
  assign b4      = snap.hdr[4];
  assign b5      = snap.hdr[5];
  assign b6      = snap.hdr[6];
  assign fs      = b4[7:6];
  assign nb      = b4[5:4];
  assign code    = b4[5:0];
  assign acm_std = b6[7:5];
  assign acm_enh = b4[3:1];
  assign sync_ok = (snap.hdr[0] == SYNC_HI) && (snap.hdr[1] == SYNC_LO);
  assign len_std = {1'b0, ac3_words(code, fs), 1'b0};
  assign len_enh = {({1'b0, b2[2:0], b3} + 12'd1), 1'b0};

  // The LFE flag moves toward the low end of the byte as the optional
  // mix level and surround mode fields appear for the given channel layout.
  always_comb begin
    lfe_idx = 3'd4;
    if (acm_std[0] && (acm_std != 3'd1)) begin
      lfe_idx = lfe_idx - 3'd2;
    end
    if (acm_std[2]) begin
      lfe_idx = lfe_idx - 3'd2;
    end
    if (acm_std == 3'd2) begin
      lfe_idx = lfe_idx - 3'd2;
    end
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.status = ST_OK;
    if (!snap.enhanced) begin
      if (snap.count < COUNT_BITS'(7)) begin
        res_nxt.status = ST_MORE;
      end else if (!sync_ok || (fs == 2'd3) || (code > 6'd37)) begin
        res_nxt.status = ST_BAD;
      end else begin
        res_nxt.frame_bytes = len_std;
        if (snap.count < COUNT_BITS'(len_std)) begin
          res_nxt.status = ST_MORE;
        end else begin
          res_nxt.sample_rate       = base_rate(fs);
          res_nxt.samples_per_frame = 11'd1536;
          res_nxt.frame_size_code   = code;
          res_nxt.stream_id         = b5[7:3];
          res_nxt.service_mode      = b5[2:0];
          res_nxt.coding_mode       = acm_std;
          res_nxt.channel_count     = CHAN_TAB[acm_std];
          res_nxt.lfe_on            = b6[lfe_idx];
        end
      end
    end else begin
      if (snap.count < COUNT_BITS'(6)) begin
        res_nxt.status = ST_MORE;
      end else if (!sync_ok) begin
        res_nxt.status = ST_BAD;
      end else begin
        res_nxt.frame_bytes = len_enh;
        if (len_enh < 13'd6) begin
          res_nxt.status = ST_BAD;
        end else if (snap.count < COUNT_BITS'(len_enh)) begin
          res_nxt.status = ST_MORE;
        end else if ((fs == 2'd3) && (nb == 2'd3)) begin
          res_nxt.status = ST_BAD;
        end else begin
          if (fs == 2'd3) begin
            res_nxt.sample_rate       = half_rate(nb);
            res_nxt.samples_per_frame = 11'd1536;
          end else begin
            res_nxt.sample_rate = base_rate(fs);
            case (nb)
              2'd0:    res_nxt.samples_per_frame = 11'd256;
              2'd1:    res_nxt.samples_per_frame = 11'd512;
              2'd2:    res_nxt.samples_per_frame = 11'd768;
              default: res_nxt.samples_per_frame = 11'd1536;
            endcase
          end
          res_nxt.stream_id     = b5[7:3];
          res_nxt.coding_mode   = acm_enh;
          res_nxt.channel_count = CHAN_TAB[acm_enh];
          res_nxt.lfe_on        = b4[0];
        end
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (snap_take) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.status            = res_r.status;
  assign out_ch.frame_bytes       = res_r.frame_bytes;
  assign out_ch.sample_rate       = res_r.sample_rate;
  assign out_ch.samples_per_frame = res_r.samples_per_frame;
  assign out_ch.frame_size_code   = res_r.frame_size_code;
  assign out_ch.stream_id         = res_r.stream_id;
  assign out_ch.service_mode      = res_r.service_mode;
  assign out_ch.coding_mode       = res_r.coding_mode;
  assign out_ch.channel_count     = res_r.channel_count;
  assign out_ch.lfe_on            = res_r.lfe_on;

endmodule

// File: rtl/core/ac3_eac3_frame_header_parser.sv
// Channel   Direction  Transfer carries
// in_ch     sink       data_byte, last_byte (one buffer byte per transfer)
// out_ch    source     status, frame_bytes and decoded header fields
// cfg_*     write      enhanced_mode (0 AC-3, 1 E-AC-3)
//
// One byte is taken per cycle while in_ch.ready is high. The transfer of a byte
// marked last loads the header snapshot register; the decoded result is loaded
// into the output register when that register is free, and is taken from there.
// Reset (rst_n low at a clock edge) clears the byte count, the mode and both
// valid flags; captured header bytes are not cleared.
// A stalled output holds its result while the snapshot stage keeps one more
// header; only then does in_ch.ready drop.
module ac3_eac3_frame_header_parser import ac3hp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  ac3hp_in_if.sink      in_ch,
  ac3hp_out_if.source   out_ch,
  input  logic          cfg_we,
  input  logic          cfg_data
);

  // Snapshot of the header bytes, count and mode for one finished buffer.
  snap_t snap;
  logic  snap_valid;
  logic  snap_take;

  // The capture stage counts bytes, keeps the first seven, and freezes them
  // when the marked byte arrives so the next buffer can start at once.
  ac3hp_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // The decoder runs the header checks in order and registers the result.
  ac3hp_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/core/ac3hp_checker.sv
module ac3hp_checker import ac3hp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  status_t     status,
  input  logic [12:0] frame_bytes,
  input  logic [15:0] sample_rate,
  input  logic [10:0] samples_per_frame,
  input  logic [2:0]  channel_count,
  input  logic        lfe_on
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_bytes))
    else $error("stalled result changed");

  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_OK) |->
      (frame_bytes != 13'd0) && (sample_rate != 16'd0) && (samples_per_frame != 11'd0)
      && (channel_count != 3'd0))
    else $error("good header with empty fields");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |->
      (sample_rate == 16'd0) && (samples_per_frame == 11'd0) && (channel_count == 3'd0)
      && !lfe_on)
    else $error("failed header carries decoded fields");

endmodule

bind ac3_eac3_frame_header_parser ac3hp_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .status            (out_ch.status),
  .frame_bytes       (out_ch.frame_bytes),
  .sample_rate       (out_ch.sample_rate),
  .samples_per_frame (out_ch.samples_per_frame),
  .channel_count     (out_ch.channel_count),
  .lfe_on            (out_ch.lfe_on)
);
